[hw/rtl/tdt_pkg.sv]
// Shared constants, types and helpers of the task dependency tracker.
package tdt_pkg;

	localparam int SLOTS         = 256;
	localparam int MAX_PREDS     = 8;
	localparam int MAX_FOLLOWERS = 16;

	localparam int ID_W    = 16;
	localparam int WAIT_W  = 4;
	localparam int FCNT_W  = 5;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int FA_W    = $clog2(SLOTS * MAX_FOLLOWERS);
	localparam int IDX_W   = $clog2(MAX_FOLLOWERS + 1);
	localparam int KEPT_W  = $clog2(MAX_PREDS + 1);

	localparam logic [1:0] OP_SUBMIT_PRED = 2'd0;
	localparam logic [1:0] OP_SUBMIT_SOLO = 2'd1;
	localparam logic [1:0] OP_COMPLETE    = 2'd2;

	// One slot record as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]   owner;
		logic              done;
		logic              kind;
		logic [WAIT_W-1:0] waiting;
		logic [FCNT_W-1:0] fcnt;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_CLAIM, S_PRED_RD, S_PRED_CHK, S_WAIT_RD, S_WAIT_WR,
		S_FIN_RD, S_FIN, S_CMP_RD, S_CMP_CHK, S_ADV_RD, S_ADV_CHK, S_FOL_RD,
		S_FOL_GET, S_FOL_CHK, S_FOL_EMIT, S_FLUSH
	} state_t;

	typedef enum logic [4:0] {
		C_NONE, C_ACCEPT, C_CLAIM, C_PRED_RD, C_PRED_ADD, C_WAIT_RD, C_WAIT_INC,
		C_FIN_RD, C_FIN, C_CMP_RD, C_CMP_MARK, C_ADV_RD, C_ADV_STEP, C_FOL_RD,
		C_FOL_GET, C_FOL_CHK, C_FOL_EMIT, C_FLUSH
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic       open;
		logic       age_ok;
		logic       pred_ok;
		logic       cmp_ok;
		logic       adv_end;
		logic       adv_step;
		logic       fol_end;
		logic       fol_emit;
		logic       pend_valid;
		logic       out_free;
	} stat_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
		return SLOT_W'(id % SLOTS);
	endfunction

endpackage

[hw/rtl/task_dependency_tracker.sv]
// Task dependency tracker top level: controller plus datapath.
//
// Input channel (in_valid/in_ready) takes one request at a time: a submit
// element with a predecessor, a submit without predecessor, or a completion.
// Output channel (out_valid/out_ready) returns one or more results per request;
// last_result marks the final one. A request with nothing to report still
// returns a single status result carrying oldest_pending.
// Steps: a submit element claims a slot (when no submission is open), reads
// and updates its predecessor, updates its own waiting count and closes. A
// completion marks its slot, moves the oldest pointer over done slots and
// walks its followers (up to 16), emitting those it frees; each slot
// read-modify-write goes through the registered-read slot memory, one access
// per cycle. in_ready is high only when idle.
// Reset clears pointers and per-slot valid bits at once; there is no clearing
// pass. A stalled receiver holds the walk at the next emitted result; one
// result is kept aside so the final one can carry last_result.
module task_dependency_tracker import tdt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      opcode,
	input  logic [ID_W-1:0] task_ref,
	input  logic            task_kind,
	input  logic            last_pred,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            ready_valid,
	output logic [ID_W-1:0] ready_task,
	output logic            ready_kind,
	output logic [ID_W-1:0] oldest_pending,
	output logic            last_result
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: at most one micro-op per cycle; it waits while the output register is busy
	tdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memories, pointers and output register
	tdt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (opcode),
		.task_ref       (task_ref),
		.task_kind      (task_kind),
		.last_pred      (last_pred),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ready_valid    (ready_valid),
		.ready_task     (ready_task),
		.ready_kind     (ready_kind),
		.oldest_pending (oldest_pending),
		.last_result    (last_result)
	);

endmodule

[hw/rtl/tdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/tdt_ctrl.sv]
// Controller state machine of the task dependency tracker.
module tdt_ctrl import tdt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = C_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = C_ACCEPT;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.op == OP_SUBMIT_PRED || stat.op == OP_SUBMIT_SOLO) begin
					if (!stat.open) begin
						state_d = S_CLAIM;
					end else if (stat.op == OP_SUBMIT_PRED) begin
						state_d = S_PRED_RD;
					end else begin
						state_d = S_FIN_RD;
					end
				end else if (stat.op == OP_COMPLETE && stat.age_ok) begin
					state_d = S_CMP_RD;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_CLAIM: begin
				cmd     = C_CLAIM;
				state_d = (stat.op == OP_SUBMIT_PRED) ? S_PRED_RD : S_FIN_RD;
			end
			S_PRED_RD: begin
				cmd     = C_PRED_RD;
				state_d = S_PRED_CHK;
			end
			S_PRED_CHK: begin
				if (stat.pred_ok) begin
					cmd     = C_PRED_ADD;
					state_d = S_WAIT_RD;
				end else begin
					state_d = stat.last ? S_FIN_RD : S_FLUSH;
				end
			end
			S_WAIT_RD: begin
				cmd     = C_WAIT_RD;
				state_d = S_WAIT_WR;
			end
			S_WAIT_WR: begin
				cmd     = C_WAIT_INC;
				state_d = stat.last ? S_FIN_RD : S_FLUSH;
			end
			S_FIN_RD: begin
				cmd     = C_FIN_RD;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd     = C_FIN;
				state_d = S_FLUSH;
			end
			S_CMP_RD: begin
				cmd     = C_CMP_RD;
				state_d = S_CMP_CHK;
			end
			S_CMP_CHK: begin
				if (stat.cmp_ok) begin
					cmd     = C_CMP_MARK;
					state_d = S_ADV_RD;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_ADV_RD: begin
				if (stat.adv_end) begin
					state_d = S_FOL_RD;
				end else begin
					cmd     = C_ADV_RD;
					state_d = S_ADV_CHK;
				end
			end
			S_ADV_CHK: begin
				if (stat.adv_step) begin
					cmd     = C_ADV_STEP;
					state_d = S_ADV_RD;
				end else begin
					state_d = S_FOL_RD;
				end
			end
			S_FOL_RD: begin
				if (stat.fol_end) begin
					state_d = S_FLUSH;
				end else begin
					cmd     = C_FOL_RD;
					state_d = S_FOL_GET;
				end
			end
			S_FOL_GET: begin
				cmd     = C_FOL_GET;
				state_d = S_FOL_CHK;
			end
			S_FOL_CHK: begin
				cmd     = C_FOL_CHK;
				state_d = stat.fol_emit ? S_FOL_EMIT : S_FOL_RD;
			end
			S_FOL_EMIT: begin
				if (!stat.pend_valid || stat.out_free) begin
					cmd     = C_FOL_EMIT;
					state_d = S_FOL_RD;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd     = C_FLUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hw/rtl/tdt_dp.sv]
// Datapath of the task dependency tracker: slot and follower memories, pointers, output.
module tdt_dp import tdt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output stat_t           stat,
	input  logic [1:0]      opcode,
	input  logic [ID_W-1:0] task_ref,
	input  logic            task_kind,
	input  logic            last_pred,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            ready_valid,
	output logic [ID_W-1:0] ready_task,
	output logic            ready_kind,
	output logic [ID_W-1:0] oldest_pending,
	output logic            last_result
);

	// request fields
	logic [1:0]      op_q;
	logic [ID_W-1:0] ref_q;
	logic            kind_q;
	logic            last_q;

	// tracker state
	logic [ID_W-1:0]   next_id_q;
	logic [ID_W-1:0]   oldest_q;
	logic [KEPT_W-1:0] kept_q;
	logic              open_q;
	logic [SLOTS-1:0]  slot_vld_q;
	logic              rd_vld_q;

	// follower walk
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [ID_W-1:0]  fol_q;
	logic             cand_kind_q;
	logic             pend_valid_q;
	logic [ID_W-1:0]  pend_task_q;
	logic             pend_kind_q;

	// output register
	logic            out_valid_q;
	logic            out_rv_q;
	logic [ID_W-1:0] out_task_q;
	logic            out_kind_q;
	logic            out_last_q;
	logic [ID_W-1:0] out_oldest_q;

	logic              s_we, s_re;
	logic [SLOT_W-1:0] s_waddr, s_raddr;
	slot_t             s_wdata, s_raw, rd;
	logic              f_we, f_re;
	logic [FA_W-1:0]   f_waddr, f_raddr;
	logic [ID_W-1:0]   f_rdata;

	logic [SLOT_W-1:0] ref_slot, next_slot, fol_slot;
	logic [ID_W-1:0]   age;
	logic              out_free;

	tdt_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_raw)
	);

	tdt_ram #(.WIDTH(ID_W), .DEPTH(SLOTS * MAX_FOLLOWERS)) u_fol_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (next_id_q),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	assign ref_slot  = slot_of(ref_q);
	assign next_slot = slot_of(next_id_q);
	assign fol_slot  = slot_of(fol_q);
	assign age       = ID_W'(next_id_q - ref_q);
	assign out_free  = !out_valid_q || out_ready;
	// never-written slot reads as its reset value
	assign rd        = rd_vld_q ? s_raw : '0;

	// memory ports
	always_comb begin
		s_re    = 1'b0;
		s_raddr = ref_slot;
		s_we    = 1'b0;
		s_waddr = ref_slot;
		s_wdata = rd;
		f_we    = 1'b0;
		f_waddr = FA_W'(FA_W'(ref_slot) * FA_W'(MAX_FOLLOWERS)) + FA_W'(rd.fcnt);
		f_re    = 1'b0;
		f_raddr = FA_W'(FA_W'(ref_slot) * FA_W'(MAX_FOLLOWERS)) + FA_W'(idx_q);
		case (cmd)
			C_CLAIM: begin
				s_we    = 1'b1;
				s_waddr = next_slot;
				s_wdata = '{owner: next_id_q, done: 1'b0, kind: kind_q, waiting: '0, fcnt: '0};
			end
			C_PRED_RD, C_CMP_RD: s_re = 1'b1;
			C_PRED_ADD: begin
				s_we         = 1'b1;
				s_wdata.fcnt = FCNT_W'(rd.fcnt + FCNT_W'(1));
				f_we         = 1'b1;
			end
			C_WAIT_RD, C_FIN_RD: begin
				s_re    = 1'b1;
				s_raddr = next_slot;
			end
			C_WAIT_INC: begin
				s_we            = 1'b1;
				s_waddr         = next_slot;
				s_wdata.waiting = WAIT_W'(rd.waiting + WAIT_W'(1));
			end
			C_CMP_MARK: begin
				s_we         = 1'b1;
				s_wdata.done = 1'b1;
			end
			C_ADV_RD: begin
				s_re    = 1'b1;
				s_raddr = slot_of(oldest_q);
			end
			C_FOL_RD: f_re = 1'b1;
			C_FOL_GET: begin
				s_re    = 1'b1;
				s_raddr = slot_of(f_rdata);
			end
			C_FOL_CHK: begin
				s_we            = (rd.waiting != '0);
				s_waddr         = fol_slot;
				s_wdata.waiting = WAIT_W'(rd.waiting - WAIT_W'(1));
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.op         = op_q;
		stat.last       = last_q;
		stat.open       = open_q;
		stat.age_ok     = (age != '0) && ({1'b0, age} <= (ID_W + 1)'(SLOTS));
		stat.pred_ok    = (rd.owner == ref_q || rd.owner == '0) && !rd.done
			&& (kept_q < KEPT_W'(MAX_PREDS)) && (rd.fcnt < FCNT_W'(MAX_FOLLOWERS));
		stat.cmp_ok     = (rd.owner == ref_q) && !rd.done;
		stat.adv_end    = (oldest_q == next_id_q);
		stat.adv_step   = (rd.owner == oldest_q) && rd.done;
		stat.fol_end    = (idx_q == cnt_q);
		// a follower still being submitted is released by its own submission end
		stat.fol_emit   = (rd.waiting == WAIT_W'(1)) && !(open_q && fol_slot == next_slot);
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q    <= '0;
			oldest_q     <= '0;
			kept_q       <= '0;
			open_q       <= 1'b0;
			slot_vld_q   <= '0;
			rd_vld_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
		end else begin
			if (s_we) begin
				slot_vld_q[s_waddr] <= 1'b1;
			end
			if (s_re) begin
				rd_vld_q <= slot_vld_q[s_raddr];
			end
			// load wins over drain; both only happen when the register is free
			if (cmd == C_FLUSH || (cmd == C_FOL_EMIT && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				C_CLAIM: begin
					kept_q <= '0;
					open_q <= 1'b1;
				end
				C_PRED_ADD: kept_q <= KEPT_W'(kept_q + KEPT_W'(1));
				C_FIN: begin
					if (rd.waiting == '0) begin
						pend_valid_q <= 1'b1;
					end
					next_id_q <= ID_W'(next_id_q + ID_W'(1));
					kept_q    <= '0;
					open_q    <= 1'b0;
				end
				C_CMP_MARK: begin
					cnt_q <= (rd.fcnt > FCNT_W'(MAX_FOLLOWERS)) ? IDX_W'(MAX_FOLLOWERS)
						: IDX_W'(rd.fcnt);
					idx_q <= '0;
				end
				C_ADV_STEP: oldest_q <= ID_W'(oldest_q + ID_W'(1));
				C_FOL_CHK:  idx_q    <= IDX_W'(idx_q + IDX_W'(1));
				C_FOL_EMIT: pend_valid_q <= 1'b1;
				C_FLUSH:    pend_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			C_ACCEPT: begin
				op_q   <= opcode;
				ref_q  <= task_ref;
				kind_q <= task_kind;
				last_q <= last_pred;
			end
			C_FIN: begin
				pend_task_q <= next_id_q;
				pend_kind_q <= rd.kind;
			end
			C_FOL_GET: fol_q       <= f_rdata;
			C_FOL_CHK: cand_kind_q <= rd.kind;
			C_FOL_EMIT: begin
				if (pend_valid_q) begin
					out_rv_q     <= 1'b1;
					out_task_q   <= pend_task_q;
					out_kind_q   <= pend_kind_q;
					out_last_q   <= 1'b0;
					out_oldest_q <= oldest_q;
				end
				pend_task_q <= fol_q;
				pend_kind_q <= cand_kind_q;
			end
			C_FLUSH: begin
				out_rv_q     <= pend_valid_q;
				out_task_q   <= pend_valid_q ? pend_task_q : '0;
				out_kind_q   <= pend_valid_q && pend_kind_q;
				out_last_q   <= 1'b1;
				out_oldest_q <= oldest_q;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign ready_valid    = out_rv_q;
	assign ready_task     = out_task_q;
	assign ready_kind     = out_kind_q;
	assign oldest_pending = out_oldest_q;
	assign last_result    = out_last_q;

endmodule

[verif/tb_task_dependency_tracker.sv]
// Self-checking testbench of the task dependency tracker.
`timescale 1ns / 1ps

module tb_task_dependency_tracker;
	import tdt_pkg::*;

	// opcode value that the block must ignore
	localparam logic [1:0] OP_RESERVED = 2'd3;

	typedef struct {
		logic            rdy;
		logic [ID_W-1:0] task_id;
		logic            kind;
		logic [ID_W-1:0] oldest;
		logic            last;
	} report_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [1:0]      opcode = OP_SUBMIT_SOLO;
	logic [ID_W-1:0] task_ref = '0;
	logic            task_kind = 1'b0;
	logic            last_pred = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic            ready_valid;
	logic [ID_W-1:0] ready_task;
	logic            ready_kind;
	logic [ID_W-1:0] oldest_pending;
	logic            last_result;

	task_dependency_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .task_ref(task_ref), .task_kind(task_kind), .last_pred(last_pred),
		.out_valid(out_valid), .out_ready(out_ready),
		.ready_valid(ready_valid), .ready_task(ready_task), .ready_kind(ready_kind),
		.oldest_pending(oldest_pending), .last_result(last_result)
	);

	always #2 clk = ~clk;

	// Shadow copy of the tracker state.
	logic [ID_W-1:0]   trk_owner [SLOTS];
	logic              trk_done [SLOTS];
	logic              trk_kind [SLOTS];
	logic [WAIT_W-1:0] trk_wait [SLOTS];
	logic [FCNT_W-1:0] trk_fcnt [SLOTS];
	logic [ID_W-1:0]   trk_follow [SLOTS*MAX_FOLLOWERS];
	logic [ID_W-1:0]   trk_next_id = '0;
	logic [ID_W-1:0]   trk_oldest = '0;
	int                trk_kept = 0;
	logic              trk_claim_open = 1'b0;

	report_t         pending_reports[$];
	logic [ID_W-1:0] open_tasks[$];     // committed, not yet completed (stimulus side)

	int  n_requests = 0;
	int  n_reports = 0;
	int  n_ready_seen = 0;
	int  n_errors = 0;
	int  burst_left = 0;
	bit  hold_req = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			trk_owner[i] = '0;
			trk_done[i] = 1'b0;
			trk_wait[i] = '0;
			trk_fcnt[i] = '0;
		end
	end

	// Work out the reports that one accepted request causes.
	task automatic predict_request(input logic [1:0] op, input logic [ID_W-1:0] ref_id,
			input logic kind, input logic last);
		logic [ID_W-1:0] hit_id[$];
		logic            hit_kind[$];
		int              s, pi, ci, fi, cnt, age;
		logic [ID_W-1:0] f;
		report_t         r;
		if (op == OP_SUBMIT_PRED || op == OP_SUBMIT_SOLO) begin
			s = trk_next_id % SLOTS;
			if (!trk_claim_open) begin
				trk_owner[s] = trk_next_id;
				trk_done[s] = 1'b0;
				trk_kind[s] = kind;
				trk_wait[s] = '0;
				trk_fcnt[s] = '0;
				trk_kept = 0;
				trk_claim_open = 1'b1;
			end
			if (op == OP_SUBMIT_PRED) begin
				pi = ref_id % SLOTS;
				// stale or finished predecessors, and overflow, add no edge
				if (!((trk_owner[pi] != ref_id && trk_owner[pi] != 0) || trk_done[pi] ||
						trk_kept >= MAX_PREDS || trk_fcnt[pi] >= MAX_FOLLOWERS)) begin
					trk_follow[pi*MAX_FOLLOWERS + trk_fcnt[pi]] = trk_next_id;
					trk_fcnt[pi] = trk_fcnt[pi] + 1'b1;
					trk_wait[s] = trk_wait[s] + 1'b1;
					trk_kept++;
				end
			end
			if (op == OP_SUBMIT_SOLO || last) begin
				if (trk_wait[s] == 0) begin
					hit_id.push_back(trk_next_id);
					hit_kind.push_back(trk_kind[s]);
				end
				trk_next_id = trk_next_id + 1'b1;
				trk_kept = 0;
				trk_claim_open = 1'b0;
			end
		end else if (op == OP_COMPLETE) begin
			ci = ref_id % SLOTS;
			age = 16'(trk_next_id - ref_id);
			if (age >= 1 && age <= SLOTS && trk_owner[ci] == ref_id && !trk_done[ci]) begin
				trk_done[ci] = 1'b1;
				for (int k = 0; k < SLOTS; k++) begin
					if (trk_oldest == trk_next_id) break;
					s = trk_oldest % SLOTS;
					if (trk_owner[s] != trk_oldest || !trk_done[s]) break;
					trk_oldest = trk_oldest + 1'b1;
				end
				cnt = trk_fcnt[ci];
				if (cnt > MAX_FOLLOWERS) cnt = MAX_FOLLOWERS;
				for (int j = 0; j < cnt; j++) begin
					f = trk_follow[ci*MAX_FOLLOWERS + j];
					fi = f % SLOTS;
					if (trk_wait[fi] == 0) continue;
					trk_wait[fi] = trk_wait[fi] - 1'b1;
					// the open submission reports itself when it closes
					if (trk_wait[fi] == 0 && !(trk_claim_open && fi == trk_next_id % SLOTS) &&
							hit_id.size() < MAX_FOLLOWERS) begin
						hit_id.push_back(f);
						hit_kind.push_back(trk_kind[fi]);
					end
				end
			end
		end
		if (hit_id.size() == 0) begin
			r = '{1'b0, '0, 1'b0, trk_oldest, 1'b1};
			pending_reports.push_back(r);
		end
		foreach (hit_id[k]) begin
			r = '{1'b1, hit_id[k], hit_kind[k], trk_oldest, k == hit_id.size() - 1};
			pending_reports.push_back(r);
		end
	endtask

	// Offer one request; the sender idles in random bursts.
	task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] ref_id,
			input logic kind, input logic last);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		task_ref <= ref_id;
		task_kind <= kind;
		last_pred <= last;
		do @(posedge clk); while (!in_ready);
		predict_request(op, ref_id, kind, last);
		n_requests++;
		if ((op == OP_SUBMIT_SOLO || op == OP_SUBMIT_PRED && last) && !trk_claim_open)
			open_tasks.push_back(trk_next_id - 1'b1);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
		end
	endtask

	task automatic complete_task(input logic [ID_W-1:0] id);
		foreach (open_tasks[k])
			if (open_tasks[k] == id) begin
				open_tasks.delete(k);
				break;
			end
		send_request(OP_COMPLETE, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Predecessor near the head of the id stream.
	function automatic logic [ID_W-1:0] recent_id();
		int span;
		span = (trk_next_id > 16) ? 16 : trk_next_id;
		if (span == 0) return '0;
		return ID_W'(trk_next_id - 1'b1 - $urandom_range(0, span - 1));
	endfunction

	// One submission of n predecessor requests, sometimes closed by a solo submit (n == 0: a solo submit).
	task automatic submit_task(input int n_preds, input logic kind);
		bit close_solo;
		close_solo = (n_preds > 0) && ($urandom_range(0, 5) == 0);
		if (n_preds == 0)
			send_request(OP_SUBMIT_SOLO, ID_W'($urandom), kind, 1'($urandom_range(0, 1)));
		for (int i = 0; i < n_preds; i++)
			send_request(OP_SUBMIT_PRED, recent_id(), kind,
				!close_solo && i == n_preds - 1);
		if (close_solo) send_request(OP_SUBMIT_SOLO, ID_W'($urandom), kind, 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: changing stall pattern, plus a long hold on request.
	initial begin
		int mode;
		int phase;
		mode = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				phase++;
				if (phase % 80 == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					default: begin
						out_ready <= (phase % 4 == 0);
					end
				endcase
			end
		end
	end

	// Compare each accepted report with the oldest expectation.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			n_reports++;
			if (pending_reports.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%t unexpected report: task %0d", $realtime, ready_task);
			end else begin
				want = pending_reports.pop_front();
				if (want.rdy) n_ready_seen++;
				if (ready_valid !== want.rdy || ready_task !== want.task_id ||
						ready_kind !== want.kind || oldest_pending !== want.oldest ||
						last_result !== want.last) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%t report mismatch: exp v%0b t%0d k%0b o%0d l%0b, got v%0b t%0d k%0b o%0d l%0b",
							$realtime, want.rdy, want.task_id, want.kind, want.oldest, want.last,
							ready_valid, ready_task, ready_kind, oldest_pending, last_result);
				end
			end
		end
	end

	// Edge cases: extremes, every opcode, stale ids, overflow, mid-submission completion.
	task automatic test_directed();
		send_request(OP_SUBMIT_SOLO, 16'hFFFF, 1'b0, 1'b1);  // task 0
		send_request(OP_SUBMIT_SOLO, 16'h0000, 1'b1, 1'b0);  // task 1
		send_request(OP_SUBMIT_PRED, 16'd0, 1'b1, 1'b1);     // task 2 waits on 0
		send_request(OP_SUBMIT_PRED, 16'hFFFF, 1'b0, 1'b1);  // never-claimed slot
		send_request(OP_RESERVED, 16'hA5A5, 1'b1, 1'b1);
		complete_task(16'h1234);                             // not committed
		complete_task(16'd2);                                // still waiting, legal
		complete_task(16'd0);
		complete_task(16'd0);                                // already done
		// more predecessors than kept
		for (int i = 0; i < MAX_PREDS + 2; i++)
			send_request(OP_SUBMIT_PRED, 16'd1, 1'b1, i == MAX_PREDS + 1);
		// completion lands while a submission is open
		send_request(OP_SUBMIT_PRED, 16'd1, 1'b0, 1'b0);
		complete_task(16'd1);
		send_request(OP_SUBMIT_SOLO, 16'h8000, 1'b1, 1'b0);
		wait_drained();
	endtask

	// Follower list overflow on one predecessor, then its completion fans out.
	task automatic test_fanout();
		logic [ID_W-1:0] root;
		root = trk_next_id;
		submit_task(0, 1'b1);
		for (int i = 0; i < MAX_FOLLOWERS + 2; i++)
			send_request(OP_SUBMIT_PRED, root, i[0], 1'b1);
		complete_task(root);
		wait_drained();
	endtask

	// Random dependency graphs with in-order and out-of-order completion.
	task automatic test_random_graph(input int n_items);
		int start;
		int idx;
		start = n_requests;
		while (n_requests - start < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: submit_task($urandom_range(0, 10), 1'($urandom_range(0, 1)));
				4, 5, 6, 7: begin
					if (open_tasks.size() != 0) begin
						idx = ($urandom_range(0, 2) == 0) ? 0 :
							$urandom_range(0, open_tasks.size() - 1);
						complete_task(open_tasks[idx]);
					end
				end
				8: complete_task(ID_W'($urandom));
				default: send_request(2'($urandom_range(0, 3)), ID_W'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	// Long receiver hold while requests keep coming, so the block backs up.
	task automatic test_backpressure();
		hold_req = 1;
		test_random_graph(40);
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_fanout();
		test_random_graph(180);
		test_backpressure();
		test_random_graph(180);
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Covered %0d requests, %0d reports checked, %0d of them naming ready tasks.",
			n_requests, n_reports, n_ready_seen);
		$display("Submits with fan-in and fan-out overflow, stale ids, and long output stalls.");
		if (n_errors == 0 && pending_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors, %0d reports missing", n_errors, pending_reports.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("Timeout with %0d reports outstanding", pending_reports.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
